// ----- src/vtbb_pkg.sv -----
// Shared types, constants and the control program of the vertex transform block.
`timescale 1ns / 1ps
package vtbb_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_ROT0  = 3'd0;
  localparam logic [2:0] REG_ROT1  = 3'd1;
  localparam logic [2:0] REG_ROT2  = 3'd2;
  localparam logic [2:0] REG_OFFX  = 3'd3;
  localparam logic [2:0] REG_OFFY  = 3'd4;
  localparam logic [2:0] REG_OFFZ  = 3'd5;
  localparam logic [2:0] REG_SCALE = 3'd6;

  localparam logic [47:0] ROT0_RST  = 48'h0001_0000_0000;
  localparam logic [47:0] ROT1_RST  = 48'h0000_4000_0000;
  localparam logic [47:0] ROT2_RST  = 48'h0000_0000_4000;
  localparam logic [15:0] SCALE_RST = 16'hFFFF;

  localparam logic signed [31:0] Q16_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q16_MIN = 32'sh8000_0000;
  localparam logic signed [51:0] RND_HALF = 52'sd8192;

  // Program counter of the sequencer
  typedef logic [2:0] upc_t;

  localparam upc_t PC_WAIT  = 3'd0;
  localparam upc_t PC_LOCAL = 3'd1;
  localparam upc_t PC_MUL0  = 3'd2;
  localparam upc_t PC_MUL1  = 3'd3;
  localparam upc_t PC_MUL2  = 3'd4;
  localparam upc_t PC_ACC2  = 3'd5;
  localparam upc_t PC_BOUND = 3'd6;

  // One control word of the program
  typedef struct packed {
    logic       wait_in;   // hold here until an input transaction
    logic       wait_out;  // hold here until the result register is free
    logic       mul_local; // multipliers form the scaled local position
    logic       mul_row;   // multipliers form one matrix row's products
    logic [1:0] mul_idx;   // matrix row for the products
    logic       acc_en;    // sum the held products into one world axis
    logic [1:0] acc_idx;   // world axis summed
    upc_t       next_pc;   // jump target once the step completes
  } ucw_t;

  // Strobes handed to the datapath for the current step
  typedef struct packed {
    logic       load_in;
    logic       mul_local;
    logic       mul_row;
    logic [1:0] mul_idx;
    logic       acc_en;
    logic [1:0] acc_idx;
    logic       bound_en;
  } dp_ctrl_t;

  // Control store
  function automatic ucw_t ucode(input upc_t pc);
    ucw_t w;
    w = '0;
    unique case (pc)
      PC_WAIT: begin
        w.wait_in = 1'b1;
        w.next_pc = PC_LOCAL;
      end
      PC_LOCAL: begin
        w.mul_local = 1'b1;
        w.next_pc   = PC_MUL0;
      end
      PC_MUL0: begin
        w.mul_row = 1'b1;
        w.mul_idx = 2'd0;
        w.next_pc = PC_MUL1;
      end
      PC_MUL1: begin
        w.mul_row = 1'b1;
        w.mul_idx = 2'd1;
        w.acc_en  = 1'b1;
        w.acc_idx = 2'd0;
        w.next_pc = PC_MUL2;
      end
      PC_MUL2: begin
        w.mul_row = 1'b1;
        w.mul_idx = 2'd2;
        w.acc_en  = 1'b1;
        w.acc_idx = 2'd1;
        w.next_pc = PC_ACC2;
      end
      PC_ACC2: begin
        w.acc_en  = 1'b1;
        w.acc_idx = 2'd2;
        w.next_pc = PC_BOUND;
      end
      PC_BOUND: begin
        w.wait_out = 1'b1;
        w.next_pc  = PC_WAIT;
      end
      default: begin
        w.next_pc = PC_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- src/vtbb_datapath.sv -----
// Datapath: three shared multipliers, row accumulator with rounding and saturation, bounds.
`timescale 1ns / 1ps
module vtbb_datapath import vtbb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_ctrl_t            ctrl,
  input  logic [47:0]         in_data,   // pos_x, pos_y, pos_z
  input  logic                in_start,
  input  logic [47:0]         rot0,
  input  logic [47:0]         rot1,
  input  logic [47:0]         rot2,
  input  logic signed [31:0]  off_x,
  input  logic signed [31:0]  off_y,
  input  logic signed [31:0]  off_z,
  input  logic [15:0]         scale,
  output logic [287:0]        res_data
);

  logic signed [15:0] pos_r   [3];
  logic               start_r;
  logic signed [31:0] local_r [3];
  logic signed [47:0] prod_r  [3];
  logic signed [31:0] world_r [3];
  logic signed [31:0] low_r   [3];
  logic signed [31:0] high_r  [3];
  logic [287:0]       res_r;

  logic [47:0]        row_sel;
  logic signed [31:0] off_sel;
  logic signed [15:0] mul_a   [3];
  logic signed [31:0] mul_b   [3];
  logic signed [47:0] prod    [3];
  logic signed [31:0] lprod   [3];
  logic signed [31:0] local_nxt [3];
  logic signed [51:0] sum;
  logic signed [37:0] shifted;
  logic signed [31:0] sat;
  logic signed [31:0] lo_base [3];
  logic signed [31:0] hi_base [3];
  logic signed [31:0] low_nxt [3];
  logic signed [31:0] high_nxt [3];

  // Operand selection for the current step
  always_comb begin
    case (ctrl.mul_idx)
      2'd0:    row_sel = rot0;
      2'd1:    row_sel = rot1;
      default: row_sel = rot2;
    endcase
    case (ctrl.acc_idx)
      2'd0:    off_sel = off_x;
      2'd1:    off_sel = off_y;
      default: off_sel = off_z;
    endcase
  end

  // Multiplier lanes, one per matrix column
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mul_a[c] = ctrl.mul_local ? pos_r[c] : $signed(row_sel[16*c +: 16]);
      mul_b[c] = ctrl.mul_local ? $signed({16'b0, scale}) : local_r[c];
      prod[c]  = mul_a[c] * mul_b[c];
      lprod[c] = prod[c][31:0];
      // y and z are mirrored into the world frame
      local_nxt[c] = (c == 0) ? lprod[c] : -lprod[c];
    end
  end

  // Row sum in Q.30, round half up, back to Q16.16 with saturation
  always_comb begin
    sum = {{4{prod_r[0][47]}}, prod_r[0]} + {{4{prod_r[1][47]}}, prod_r[1]}
        + {{4{prod_r[2][47]}}, prod_r[2]}
        + {{6{off_sel[31]}}, off_sel, 14'b0} + RND_HALF;
    shifted = sum[51:14];
    if (shifted[37:31] != {7{shifted[37]}}) begin
      sat = shifted[37] ? Q16_MIN : Q16_MAX;
    end else begin
      sat = shifted[31:0];
    end
  end

  // Bounds after this vertex
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lo_base[c]  = start_r ? Q16_MAX : low_r[c];
      hi_base[c]  = start_r ? Q16_MIN : high_r[c];
      low_nxt[c]  = (world_r[c] < lo_base[c]) ? world_r[c] : lo_base[c];
      high_nxt[c] = (world_r[c] > hi_base[c]) ? world_r[c] : hi_base[c];
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      pos_r[0] <= in_data[15:0];
      pos_r[1] <= in_data[31:16];
      pos_r[2] <= in_data[47:32];
      start_r  <= in_start;
    end
    for (int c = 0; c < 3; c++) begin
      if (ctrl.mul_local) begin
        local_r[c] <= local_nxt[c];
      end
      if (ctrl.mul_row) begin
        prod_r[c] <= prod[c];
      end
      if (ctrl.acc_en && ctrl.acc_idx == 2'(c)) begin
        world_r[c] <= sat;
      end
    end
    if (ctrl.bound_en) begin
      res_r <= {high_nxt[2], high_nxt[1], high_nxt[0],
                low_nxt[2], low_nxt[1], low_nxt[0],
                world_r[2], world_r[1], world_r[0]};
    end
  end

  // Running bounds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) begin
        low_r[c]  <= Q16_MAX;
        high_r[c] <= Q16_MIN;
      end
    end else if (ctrl.bound_en) begin
      for (int c = 0; c < 3; c++) begin
        low_r[c]  <= low_nxt[c];
        high_r[c] <= high_nxt[c];
      end
    end
  end

  assign res_data = res_r;

endmodule

// ----- src/vertex_transform_bounding_box.sv -----
// Top level: configuration registers, microprogram sequencer and result register.
`timescale 1ns / 1ps
// Transforms one signed 16-bit model vertex per input transaction: scale by unit_scale
// (Q0.16), mirror y and z, rotate by the Q2.14 matrix, translate, round half up and
// saturate to Q16.16, then fold the position into per-axis running bounds (reset
// before a vertex whose object_start flag is set). A vertex passes through the accept
// step and six steps of the control program, set by the three 16x32 multipliers
// being reused for the local position and each of the three matrix rows.
// The result sits in an output register, so the next vertex is accepted while it
// waits to be taken. Configuration writes are taken in any cycle outside reset and
// should only be made while no vertex is in progress.
module vertex_transform_bounding_box import vtbb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  // input vertices
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // pos_x, pos_y, pos_z
  input  logic         in_tuser,   // object_start
  // results
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [287:0] out_tdata,  // world_x/y/z, bound_min_x/y/z, bound_max_x/y/z
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  logic [47:0]        rot0_r, rot1_r, rot2_r;
  logic signed [31:0] offx_r, offy_r, offz_r;
  logic [15:0]        scale_r;
  upc_t               pc_r, pc_nxt;
  logic               out_valid_r, out_valid_nxt;
  ucw_t               uw;
  logic               in_acc;
  logic               out_free;
  logic               advance;
  dp_ctrl_t           dctl;

  // No transaction is taken while reset is held
  assign cfg_ready = rst_n;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot0_r  <= ROT0_RST;
      rot1_r  <= ROT1_RST;
      rot2_r  <= ROT2_RST;
      offx_r  <= '0;
      offy_r  <= '0;
      offz_r  <= '0;
      scale_r <= SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROT0:  rot0_r  <= cfg_data;
        REG_ROT1:  rot1_r  <= cfg_data;
        REG_ROT2:  rot2_r  <= cfg_data;
        REG_OFFX:  offx_r  <= cfg_data[31:0];
        REG_OFFY:  offy_r  <= cfg_data[31:0];
        REG_OFFZ:  offz_r  <= cfg_data[31:0];
        REG_SCALE: scale_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer: fetch, conditional hold, jump
  always_comb begin
    uw        = ucode(pc_r);
    in_tready = uw.wait_in && rst_n;
    in_acc    = in_tvalid && in_tready;
    out_free  = !out_valid_r || out_tready;
    advance   = (!uw.wait_in || in_acc) && (!uw.wait_out || out_free);
    pc_nxt    = advance ? uw.next_pc : pc_r;

    dctl.load_in   = in_acc;
    dctl.mul_local = uw.mul_local;
    dctl.mul_row   = uw.mul_row;
    dctl.mul_idx   = uw.mul_idx;
    dctl.acc_en    = uw.acc_en;
    dctl.acc_idx   = uw.acc_idx;
    dctl.bound_en  = uw.wait_out && advance;

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (dctl.bound_en) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  vtbb_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (dctl),
    .in_data  (in_tdata),
    .in_start (in_tuser),
    .rot0     (rot0_r),
    .rot1     (rot1_r),
    .rot2     (rot2_r),
    .off_x    (offx_r),
    .off_y    (offy_r),
    .off_z    (offz_r),
    .scale    (scale_r),
    .res_data (out_tdata)
  );

endmodule

// ----- dv/vertex_transform_bounding_box_test.sv -----
// Self-checking testbench for the vertex transform and bounding box block.
`timescale 1ns / 1ps
module vertex_transform_bounding_box_test;
  import vtbb_pkg::*;

  localparam logic [2:0] REG_UNUSED   = 3'd7;     // index with no register behind it
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         DRAIN_CYCLES = 12;
  localparam int         OBJ_MAX_LEN  = 12;

  // One result transaction, world_x in the lowest bits
  typedef struct packed {
    logic [2:0][31:0] hi;
    logic [2:0][31:0] lo;
    logic [2:0][31:0] pos;
  } vtx_result_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata   = '0;   // pos_x, pos_y, pos_z
  logic         in_tuser   = 1'b0; // object_start
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [287:0] out_tdata;         // world_x/y/z, bound_min_x/y/z, bound_max_x/y/z
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index  = REG_ROT0;
  logic [47:0]  cfg_data   = '0;

  // Shadow copy of the configuration and the running bounds
  logic [47:0]        mat_row [3];
  logic signed [31:0] world_offset [3];
  logic [15:0]        unit_scale_q;
  logic signed [31:0] box_low [3];
  logic signed [31:0] box_high [3];

  vtx_result_t pending_results [$];

  int idle_pct_in   = 8;
  int stall_pct_out = 51;
  int error_count   = 0;
  int vertex_count  = 0;
  int object_count  = 0;
  int write_count   = 0;
  int cycle_count   = 0;

  string field_names [9] = '{"world_x", "world_y", "world_z",
                             "bound_min_x", "bound_min_y", "bound_min_z",
                             "bound_max_x", "bound_max_y", "bound_max_z"};

  vertex_transform_bounding_box i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_bounds();
    int a;
    for (a = 0; a < 3; a++) begin
      box_low[a]  = Q16_MAX;
      box_high[a] = Q16_MIN;
    end
  endfunction

  function automatic void apply_register(input logic [2:0] idx, input logic [47:0] data);
    case (idx)
      REG_ROT0:  mat_row[0]      = data;
      REG_ROT1:  mat_row[1]      = data;
      REG_ROT2:  mat_row[2]      = data;
      REG_OFFX:  world_offset[0] = data[31:0];
      REG_OFFY:  world_offset[1] = data[31:0];
      REG_OFFZ:  world_offset[2] = data[31:0];
      REG_SCALE: unit_scale_q    = data[15:0];
      default: ;  // no register, write dropped
    endcase
  endfunction

  // One matrix row against the local position, plus offset, rounded and saturated
  function automatic logic signed [31:0] rotate_axis(input int r, input longint lx,
                                                     input longint ly, input longint lz);
    logic signed [15:0] e0, e1, e2;
    longint acc;
    e0  = mat_row[r][15:0];
    e1  = mat_row[r][31:16];
    e2  = mat_row[r][47:32];
    acc = world_offset[r];
    acc = acc * 64'sd16384 + e0 * lx + e1 * ly + e2 * lz;
    acc = (acc + 64'sd8192) >>> 14;  // round half toward plus infinity
    if (acc > longint'(Q16_MAX)) return Q16_MAX;
    if (acc < longint'(Q16_MIN)) return Q16_MIN;
    return acc[31:0];
  endfunction

  function automatic vtx_result_t transform_vertex(input logic [47:0] pos, input logic start);
    vtx_result_t        res;
    longint             scale, loc [3];
    logic signed [15:0] coord;
    logic signed [31:0] w;
    int                 a;
    scale = unit_scale_q;
    for (a = 0; a < 3; a++) begin
      coord  = pos[16*a +: 16];
      loc[a] = coord;
      loc[a] = loc[a] * scale;
      if (a != 0) loc[a] = -loc[a];  // y and z mirrored
    end
    if (start) clear_bounds();
    for (a = 0; a < 3; a++) begin
      w = rotate_axis(a, loc[0], loc[1], loc[2]);
      if (w < box_low[a])  box_low[a]  = w;
      if (w > box_high[a]) box_high[a] = w;
      res.pos[a] = w;
      res.lo[a]  = box_low[a];
      res.hi[a]  = box_high[a];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    logic [8:0][31:0] got, want;
    int f;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with no vertex outstanding");
      end else begin
        want = pending_results.pop_front();
        got  = out_tdata;
        for (f = 0; f < 9; f++) begin
          if (got[f] !== want[f])
            report_mismatch($sformatf("%s got %h expected %h", field_names[f], got[f],
                                      want[f]));
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct_out);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("vertex_transform_bounding_box_test NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers

  // valid stays high between back-to-back vertices; it only drops for a gap
  task automatic send_vertex(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input logic start);
    int gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct_in) gap = $urandom_range(4, 1);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    pending_results = {pending_results, transform_vertex({z, y, x}, start)};
    vertex_count++;
    if (start) object_count++;
  endtask

  // Wait until the block has nothing in flight
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [47:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    write_count++;
  endtask

  task automatic load_config(input logic [47:0] r0, input logic [47:0] r1,
                             input logic [47:0] r2, input logic [47:0] ox,
                             input logic [47:0] oy, input logic [47:0] oz,
                             input logic [47:0] scale);
    settle_block();
    write_register(REG_ROT0, r0);
    write_register(REG_ROT1, r1);
    write_register(REG_ROT2, r2);
    write_register(REG_OFFX, ox);
    write_register(REG_OFFY, oy);
    write_register(REG_OFFZ, oz);
    write_register(REG_SCALE, scale);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- random sources

  function automatic logic [15:0] random_coord();
    case ($urandom_range(15))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Either any bit pattern or entries within about +-1.0
  function automatic logic [47:0] random_row();
    logic [47:0] row;
    int c;
    row = 48'({$urandom, $urandom});
    if ($urandom_range(1)) begin
      for (c = 0; c < 3; c++) row[16*c +: 16] = 16'($urandom_range(32768) - 16384);
    end
    return row;
  endfunction

  // Upper 16 bits are junk the block must drop; often a small offset
  function automatic logic [47:0] random_offset();
    logic [47:0] off;
    off = 48'({$urandom, $urandom});
    if ($urandom_range(1)) off[31:20] = {12{off[19]}};
    return off;
  endfunction

  task automatic random_config();
    logic [47:0] scale;
    scale = 48'({$urandom, $urandom});
    case ($urandom_range(5))
      0:       scale[15:0] = 16'h0000;
      1:       scale[15:0] = 16'hFFFF;
      default: ;
    endcase
    load_config(random_row(), random_row(), random_row(), random_offset(),
                random_offset(), random_offset(), scale);
  endtask

  // One object: a start vertex and a run of follow-ons, sometimes a stray start
  task automatic send_object(output int sent);
    int len, k;
    len = $urandom_range(OBJ_MAX_LEN, 1);
    send_vertex(random_coord(), random_coord(), random_coord(), 1'b1);
    for (k = 1; k < len; k++)
      send_vertex(random_coord(), random_coord(), random_coord(),
                  ($urandom_range(19) == 0));
    sent = len;
  endtask

  // ---------------------------------------------------------------- tests

  // Bounds start from their reset values when no object start has been seen
  task automatic test_reset_state();
    send_vertex(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_vertex(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
    send_vertex(16'h8000, 16'h7FFF, 16'h8000, 1'b0);
    send_vertex(16'h0001, 16'h0001, 16'h0001, 1'b1);
  endtask

  // Smallest matrix entry on the diagonal puts results right on the half point
  task automatic test_rounding();
    load_config(48'h0000_0000_0001, 48'h0000_0001_0000, 48'h0001_0000_0000,
                48'h0, 48'h0, 48'h0, 48'h2000);
    send_vertex(16'h0001, 16'h0001, 16'h0001, 1'b1);
    send_vertex(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_vertex(16'h0003, 16'hFFFD, 16'h0003, 1'b0);
    load_config(48'h0000_0000_0001, 48'h0000_0001_0000, 48'h0001_0000_0000,
                48'h0, 48'h0, 48'h0, 48'h6000);
    send_vertex(16'h0001, 16'hFFFF, 16'h0005, 1'b1);
  endtask

  // Extreme entries, offsets and scale drive all axes into saturation
  task automatic test_saturation();
    load_config({3{16'h7FFF}}, {3{16'h8000}}, {16'h8000, 16'h7FFF, 16'h8000},
                48'hFFFF_7FFF_FFFF, 48'hA5A5_8000_0000, 48'h0,
                48'hFFFF_FFFF_FFFF);
    send_vertex(16'h7FFF, 16'h8000, 16'h8000, 1'b1);
    send_vertex(16'h8000, 16'h7FFF, 16'h7FFF, 1'b0);
    send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_vertex(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_vertex(16'h0000, 16'h0000, 16'h0000, 1'b1);
    // zero scale leaves only the offsets
    load_config({3{16'h7FFF}}, {3{16'h8000}}, {3{16'hFFFF}},
                48'h0000_8000_0000, 48'h1234_7FFF_FFFF, 48'hFFFF_FFFF_FFFF,
                48'hFFFF_FFFF_0000);
    send_vertex(16'h7FFF, 16'h8000, 16'h7FFF, 1'b1);
    send_vertex(16'h8000, 16'h7FFF, 16'h8000, 1'b0);
  endtask

  // A write to an index with no register must leave the configuration alone
  task automatic test_unused_index();
    load_config(48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000,
                48'h0000_0001_0000, 48'h0000_FFFF_0000, 48'h0, 48'h8000);
    write_register(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_vertex(16'h0010, 16'h0020, 16'hFFF0, 1'b1);
    send_vertex(16'h8000, 16'h7FFF, 16'h0001, 1'b0);
  endtask

  // Objects of random content under several random configurations
  task automatic test_random_stream(input int pct_in, input int pct_out);
    int blk, sent, n;
    idle_pct_in   = pct_in;
    stall_pct_out = pct_out;
    for (blk = 0; blk < 5; blk++) begin
      random_config();
      n = 0;
      while (n < 25) begin
        send_object(sent);
        n += sent;
      end
    end
  endtask

  initial begin : run_tests
    mat_row[0]      = ROT0_RST;
    mat_row[1]      = ROT1_RST;
    mat_row[2]      = ROT2_RST;
    world_offset[0] = '0;
    world_offset[1] = '0;
    world_offset[2] = '0;
    unit_scale_q    = SCALE_RST;
    clear_bounds();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_rounding();
    test_saturation();
    test_unused_index();
    test_random_stream(8, 51);
    test_random_stream(51, 8);
    test_random_stream(0, 0);
    settle_block();

    $display("covered %0d vertices in %0d objects across %0d register writes",
             vertex_count, object_count, write_count);
    $display("mismatches: %0d", error_count);
    if (error_count == 0) begin
      $display("vertex_transform_bounding_box_test OK");
    end else begin
      $display("vertex_transform_bounding_box_test NOT OK");
    end
    $finish;
  end

endmodule
